### rtl/bcs_pkg.sv
package bcs_pkg;

  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned ADDR_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned COORD_W = 24;
  localparam int unsigned T_W = 17;
  localparam int unsigned SEG_W = 6;
  localparam int unsigned DIV_CNT_W = $clog2(T_W);
  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(16);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  localparam int unsigned POINT_W = $bits(point_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEVEL,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

### rtl/bcs_stream_if.sv
interface bcs_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [bcs_pkg::COORD_W-1:0]  point_x;
  logic signed [bcs_pkg::COORD_W-1:0]  point_y;
  logic                                last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface bcs_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [bcs_pkg::COORD_W-1:0]  curve_x;
  logic signed [bcs_pkg::COORD_W-1:0]  curve_y;
  logic                                last_sample;

  modport source (output valid, curve_x, curve_y, last_sample, input ready);
  modport sink (input valid, curve_x, curve_y, last_sample, output ready);
endinterface

### rtl/bcs_ram.sv
module bcs_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/bezier_curve_sampler.sv
// After the marked point, a reciprocal step computes the parameter increment,
// then each sample is built level by level over L = n-1 down to 1 and then
// loaded into the output register (n is the number of stored points).
// Throughput: one point beat per cycle while loading; no point is taken while
// a curve is being sampled. Reset is asynchronous: count cleared, segment_count 16.
module bezier_curve_sampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bcs_pkg::SEG_W-1:0]   cfg_wdata_i,
  bcs_point_if.sink                   point_i,
  bcs_sample_if.source                sample_o
);

  localparam int unsigned AW = bcs_pkg::ADDR_W;
  localparam int unsigned CW = bcs_pkg::COORD_W;
  localparam int unsigned TW = bcs_pkg::T_W;
  localparam int unsigned SW = bcs_pkg::SEG_W;
  localparam int unsigned PW = CW + TW + 1;

  bcs_pkg::state_e state_q, state_d;

  logic [SW-1:0]                 seg_cfg_q, segs_q;
  logic [bcs_pkg::CNT_W-1:0]     cnt_q, n_q;
  logic [AW-1:0]                 level_q, k_q;
  logic                          first_q;
  logic [SW-1:0]                 j_q;
  logic [TW-1:0]                 t_q, quot_q;
  logic [SW:0]                   rem_q, r_q;
  logic [bcs_pkg::DIV_CNT_W-1:0] dcnt_q;

  logic                          rd_v_q, s1_v_q, s2_v_q;
  logic [AW-1:0]                 rd_k_q, k1_q, k2_q;
  bcs_pkg::point_t               prev_q, a1_q, a2_q, res_q;
  logic signed [CW:0]            dx_q, dy_q;
  logic signed [PW-1:0]          px_q, py_q;

  logic                          ov_q, olast_q;
  bcs_pkg::point_t               oval_q;

  logic                          in_fire, ctl_we, scr_we, out_load, pipe_empty;
  logic                          last_issue, div_done, is_final;
  bcs_pkg::point_t               in_pt, ctl_rd, scr_rd, rd, wr;
  logic [SW:0]                   trial, rsum;

  assign in_pt.x = point_i.point_x;
  assign in_pt.y = point_i.point_y;
  assign in_fire = point_i.valid && point_i.ready;
  assign ctl_we = in_fire && (cnt_q < bcs_pkg::CNT_W'(bcs_pkg::MAX_POINTS));
  assign rd = first_q ? ctl_rd : scr_rd;
  assign wr.x = a2_q.x + px_q[TW-1 +: CW];
  assign wr.y = a2_q.y + py_q[TW-1 +: CW];
  assign scr_we = s2_v_q;
  assign pipe_empty = !rd_v_q && !s1_v_q && !s2_v_q;
  assign last_issue = (k_q == level_q);
  assign div_done = (dcnt_q == '0);
  assign is_final = (j_q == segs_q);
  assign out_load = (state_q == bcs_pkg::ST_EMIT) && (!ov_q || sample_o.ready);
  assign trial = {rem_q[SW-1:0], (dcnt_q == bcs_pkg::DIV_CNT_W'(TW - 1))};
  assign rsum = r_q + rem_q;

  bcs_ram #(.WIDTH(bcs_pkg::POINT_W), .DEPTH(bcs_pkg::MAX_POINTS)) u_ctl_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_pt),
    .raddr_i (k_q),
    .rdata_o (ctl_rd)
  );

  bcs_ram #(.WIDTH(bcs_pkg::POINT_W), .DEPTH(bcs_pkg::MAX_POINTS)) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (k2_q),
    .wdata_i (wr),
    .raddr_i (k_q),
    .rdata_o (scr_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcs_pkg::ST_IDLE:  if (in_fire && point_i.last_point) state_d = bcs_pkg::ST_DIV;
      bcs_pkg::ST_DIV:   if (div_done) state_d = bcs_pkg::ST_LEVEL;
      bcs_pkg::ST_LEVEL: if (last_issue) state_d = bcs_pkg::ST_DRAIN;
      bcs_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = (level_q <= AW'(1)) ? bcs_pkg::ST_EMIT : bcs_pkg::ST_LEVEL;
        end
      end
      bcs_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = is_final ? bcs_pkg::ST_IDLE : bcs_pkg::ST_LEVEL;
        end
      end
      default: state_d = bcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    point_i.ready = (state_q == bcs_pkg::ST_IDLE);
    sample_o.valid = ov_q;
    sample_o.curve_x = oval_q.x;
    sample_o.curve_y = oval_q.y;
    sample_o.last_sample = olast_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcs_pkg::ST_IDLE;
      seg_cfg_q <= bcs_pkg::SEG_RESET;
      cnt_q <= '0;
      rd_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        seg_cfg_q <= cfg_wdata_i;
      end
      if (in_fire && point_i.last_point) begin
        cnt_q <= '0;
      end else if (ctl_we) begin
        cnt_q <= cnt_q + 1'b1;
      end
      rd_v_q <= (state_q == bcs_pkg::ST_LEVEL);
      s1_v_q <= rd_v_q && (rd_k_q != '0);
      s2_v_q <= s1_v_q;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (sample_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k_q <= k_q;
    if (rd_v_q) begin
      prev_q <= rd;
      a1_q <= prev_q;
      k1_q <= rd_k_q - 1'b1;
      dx_q <= (CW+1)'(rd.x) - (CW+1)'(prev_q.x);
      dy_q <= (CW+1)'(rd.y) - (CW+1)'(prev_q.y);
      if (level_q == '0) begin
        res_q <= rd;
      end
    end
    a2_q <= a1_q;
    k2_q <= k1_q;
    px_q <= PW'(dx_q * $signed({1'b0, t_q}));
    py_q <= PW'(dy_q * $signed({1'b0, t_q}));
    if (s2_v_q && (level_q == AW'(1))) begin
      res_q <= wr;
    end
    if (out_load) begin
      oval_q <= res_q;
      olast_q <= is_final;
    end

    unique case (state_q)
      bcs_pkg::ST_IDLE: begin
        if (in_fire && point_i.last_point) begin
          n_q <= ctl_we ? cnt_q + 1'b1 : cnt_q;
          segs_q <= (seg_cfg_q == '0) ? SW'(1) : seg_cfg_q;
          dcnt_q <= bcs_pkg::DIV_CNT_W'(TW - 1);
          rem_q <= '0;
          quot_q <= '0;
        end
      end
      bcs_pkg::ST_DIV: begin
        dcnt_q <= dcnt_q - 1'b1;
        if (trial >= {1'b0, segs_q}) begin
          rem_q <= trial - {1'b0, segs_q};
          quot_q <= {quot_q[TW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quot_q <= {quot_q[TW-2:0], 1'b0};
        end
        if (div_done) begin
          j_q <= '0;
          t_q <= '0;
          r_q <= '0;
          level_q <= AW'(n_q - 1'b1);
          k_q <= '0;
          first_q <= 1'b1;
        end
      end
      bcs_pkg::ST_LEVEL: begin
        if (!last_issue) begin
          k_q <= k_q + 1'b1;
        end
      end
      bcs_pkg::ST_DRAIN: begin
        if (pipe_empty && (level_q > AW'(1))) begin
          level_q <= level_q - 1'b1;
          k_q <= '0;
          first_q <= 1'b0;
        end
      end
      bcs_pkg::ST_EMIT: begin
        if (out_load && !is_final) begin
          j_q <= j_q + 1'b1;
          level_q <= AW'(n_q - 1'b1);
          k_q <= '0;
          first_q <= 1'b1;
          if (rsum >= {1'b0, segs_q}) begin
            r_q <= rsum - {1'b0, segs_q};
            t_q <= t_q + quot_q + 1'b1;
          end else begin
            r_q <= rsum;
            t_q <= t_q + quot_q;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/bcs_checker.sv
module bcs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_last_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_last_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_last_i))
    else $error("Output beat dropped while stalled.");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last_i |=> !in_ready_i)
    else $error("Input taken while a curve is being sampled.");

  a_plain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_last_i |=> in_ready_i)
    else $error("Loading stalled after an unmarked point.");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i && out_last_i)
    else $error("Curve ended without its final sample.");

endmodule

bind bezier_curve_sampler bcs_checker u_bcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .in_last_i   (point_i.last_point),
  .out_valid_i (sample_o.valid),
  .out_ready_i (sample_o.ready),
  .out_last_i  (sample_o.last_sample)
);
